FILE: sv/smx_pkg.sv
package smx_pkg;

    localparam int SMX_GAIN_FRACTION_BITS = 14;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 15;
    localparam int MODE_W   = 2;

    // Stream payload widths: 6 data fields packed and padded to whole bytes.
    localparam int IN_DATA_W  = 96;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 32;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // Pan modes. The fourth code mixes both sides, like PAN_BOTH.
    localparam logic [MODE_W-1:0] PAN_BOTH  = 2'd0;
    localparam logic [MODE_W-1:0] PAN_RIGHT = 2'd1;
    localparam logic [MODE_W-1:0] PAN_LEFT  = 2'd2;

    typedef struct packed {
        logic seed;
        logic mix_en;
    } side_ctl_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] base_left;
        logic signed [SAMPLE_W-1:0] base_right;
        logic signed [SAMPLE_W-1:0] sample_left;
        logic signed [SAMPLE_W-1:0] sample_right;
        logic                       is_stereo;
        logic [MODE_W-1:0]          pan_mode;
        logic [GAIN_W-1:0]          gain_left;
        logic [GAIN_W-1:0]          gain_right;
        logic                       first_in_frame;
        logic                       last_in_frame;
    } voice_t;

endpackage

FILE: sv/smx_side.sv
module smx_side #(
    parameter int GAIN_FRACTION_BITS = smx_pkg::SMX_GAIN_FRACTION_BITS
) (
    input  smx_pkg::side_ctl_t                 ctl,
    input  logic signed [smx_pkg::SAMPLE_W-1:0] acc,
    input  logic signed [smx_pkg::SAMPLE_W-1:0] base,
    input  logic signed [smx_pkg::SAMPLE_W-1:0] sample,
    input  logic [smx_pkg::GAIN_W-1:0]          gain,
    output logic signed [smx_pkg::SAMPLE_W-1:0] acc_next
);
    import smx_pkg::*;

    localparam int GainSatW = (GAIN_W > GAIN_FRACTION_BITS + 1) ? GAIN_W
                                                                 : GAIN_FRACTION_BITS + 1;
    localparam int ProdW = SAMPLE_W + GainSatW + 1;
    localparam int SumW  = SAMPLE_W + 2;
    localparam logic [GainSatW-1:0] Unity =
        {{(GainSatW-1){1'b0}}, 1'b1} << GAIN_FRACTION_BITS;

    logic [GainSatW-1:0]      gain_ext;
    logic [GainSatW-1:0]      gain_sat;
    logic signed [ProdW-1:0]  prod;
    logic signed [ProdW-1:0]  prod_shift;
    logic signed [SumW-1:0]   term;
    logic signed [SAMPLE_W-1:0] start;
    logic signed [SumW-1:0]   sum;

    assign gain_ext = GainSatW'(gain);
    assign gain_sat = (gain_ext > Unity) ? Unity : gain_ext;

    assign prod       = ProdW'($signed({1'b0, gain_sat})) * ProdW'(sample);
    // The arithmetic shift rounds toward minus infinity; the term fits in 17 bits.
    assign prod_shift = prod >>> GAIN_FRACTION_BITS;
    assign term       = prod_shift[SumW-1:0];

    assign start = ctl.seed ? base : acc;
    assign sum   = SumW'(start) + term;

    always_comb
    begin
        if (!ctl.mix_en)
        begin
            acc_next = start;
        end
        else if (sum > SumW'(SAMPLE_MAX))
        begin
            acc_next = SAMPLE_MAX;
        end
        else if (sum < SumW'(SAMPLE_MIN))
        begin
            acc_next = SAMPLE_MIN;
        end
        else
        begin
            acc_next = sum[SAMPLE_W-1:0];
        end
    end

endmodule

FILE: sv/stereo_pan_saturating_mixer.sv
// Stereo pan mixer: each input transfer carries one voice, and its scaled samples
// are added, with clipping to 16 bits, into a left and a right accumulator, as the
// pan mode allows. The transfer with tlast set returns the mixed frame once its
// voice leaves the input register, and its frame is loaded into the output register
// at the same edge that the voice leaves. One voice is taken per clock cycle unless
// a frame transfer waits; the only loop is the accumulator update, which is a single
// multiply, add and clip per side between the input register and the accumulators.
// A frame transfer waits only while the output register still holds an earlier
// frame that has not been taken.
module stereo_pan_saturating_mixer #(
    parameter int GAIN_FRACTION_BITS = smx_pkg::SMX_GAIN_FRACTION_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // base_left, base_right, sample_left, sample_right, gain_left, gain_right, zero pad
    input  logic [smx_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // is_stereo, pan_mode, first_in_frame
    input  logic [smx_pkg::IN_USER_W-1:0]    s_axis_tuser,
    // last_in_frame
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_left, out_right
    output logic [smx_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import smx_pkg::*;

    voice_t                     voice_in;
    voice_t                     voice_reg;
    logic                       in_valid_reg;
    logic                       out_valid_reg;
    logic [OUT_DATA_W-1:0]      out_data_reg;
    logic signed [SAMPLE_W-1:0] acc_left_reg;
    logic signed [SAMPLE_W-1:0] acc_right_reg;
    logic signed [SAMPLE_W-1:0] acc_left_next;
    logic signed [SAMPLE_W-1:0] acc_right_next;
    logic signed [SAMPLE_W-1:0] sample_r;
    side_ctl_t                  ctl_left;
    side_ctl_t                  ctl_right;
    logic                       out_free;
    logic                       advance;

    assign voice_in.base_left      = s_axis_tdata[15:0];
    assign voice_in.base_right     = s_axis_tdata[31:16];
    assign voice_in.sample_left    = s_axis_tdata[47:32];
    assign voice_in.sample_right   = s_axis_tdata[63:48];
    assign voice_in.gain_left      = s_axis_tdata[78:64];
    assign voice_in.gain_right     = s_axis_tdata[93:79];
    assign voice_in.is_stereo      = s_axis_tuser[0];
    assign voice_in.pan_mode       = s_axis_tuser[2:1];
    assign voice_in.first_in_frame = s_axis_tuser[3];
    assign voice_in.last_in_frame  = s_axis_tlast;

    // Only a frame-ending voice needs room in the output register.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!voice_reg.last_in_frame || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    assign sample_r = voice_reg.is_stereo ? voice_reg.sample_right : voice_reg.sample_left;

    assign ctl_left.seed    = voice_reg.first_in_frame;
    assign ctl_left.mix_en  = (voice_reg.pan_mode != PAN_RIGHT);
    assign ctl_right.seed   = voice_reg.first_in_frame;
    assign ctl_right.mix_en = (voice_reg.pan_mode != PAN_LEFT);

    smx_side #(
        .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
    ) u_side_left (
        .ctl      (ctl_left),
        .acc      (acc_left_reg),
        .base     (voice_reg.base_left),
        .sample   (voice_reg.sample_left),
        .gain     (voice_reg.gain_left),
        .acc_next (acc_left_next)
    );

    smx_side #(
        .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
    ) u_side_right (
        .ctl      (ctl_right),
        .acc      (acc_right_reg),
        .base     (voice_reg.base_right),
        .sample   (sample_r),
        .gain     (voice_reg.gain_right),
        .acc_next (acc_right_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_left_reg  <= '0;
            acc_right_reg <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                acc_left_reg  <= acc_left_next;
                acc_right_reg <= acc_right_next;
            end
            if (advance && voice_reg.last_in_frame)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            voice_reg <= voice_in;
        end
        if (advance && voice_reg.last_in_frame)
        begin
            out_data_reg <= {acc_right_next, acc_left_next};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_frame_emitted: assert property (@(posedge clk) disable iff (!rst_n)
        advance && voice_reg.last_in_frame |=> m_axis_tvalid)
        else $error("frame-ending voice did not produce an output transfer");

    a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(acc_left_reg) && $stable(acc_right_reg))
        else $error("accumulators changed without a voice leaving the input register");

    a_left_only: assert property (@(posedge clk) disable iff (!rst_n)
        advance && voice_reg.pan_mode == PAN_LEFT && !voice_reg.first_in_frame
        |=> $stable(acc_right_reg))
        else $error("left-only voice changed the right accumulator");

    a_right_only: assert property (@(posedge clk) disable iff (!rst_n)
        advance && voice_reg.pan_mode == PAN_RIGHT && !voice_reg.first_in_frame
        |=> $stable(acc_left_reg))
        else $error("right-only voice changed the left accumulator");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input stalled while the input register is empty");
`endif

endmodule
